@@ design/mfm_pkg.sv @@
// Shared types and constants of the MFM track sector decoder.
`default_nettype none

package mfm_pkg;

	// Decoder phases.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_INFO  = 3'd1,
		PH_SKIP  = 3'd2,
		PH_ODD   = 3'd3,
		PH_EVEN  = 3'd4,
		PH_NEXT  = 3'd5,
		PH_HUNT  = 3'd6,
		PH_SYNCS = 3'd7
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		ST_DATA       = 2'd0,
		ST_BAD_TRACK  = 2'd1,
		ST_BAD_SECTOR = 2'd2
	} status_t;

	// Register indexes of the configuration port.
	localparam logic REG_SYNC_WORD = 1'b0;

	localparam logic [15:0] SYNC_RESET = 16'h4489;
	localparam logic [31:0] MFM_MASK   = 32'h5555_5555;
	localparam int          SKIP_WORDS = 24;
	localparam int          NEXT_WORDS = 4;
	localparam int          OFF_W      = 13;
	localparam int          APB_ADDR_W = 3;

	// Combines the odd and even halves of one MFM-coded longword.
	function automatic logic [31:0] mfm_join(input logic [31:0] odd, input logic [31:0] even);
		mfm_join = ((odd & MFM_MASK) << 1) | (even & MFM_MASK);
	endfunction

endpackage

`default_nettype wire

@@ design/mfm_track_sector_decoder.sv @@
// Top level of the MFM track sector decoder: sequencer, odd-long store and result register.
//
//  Channel   Dir  Handshake              Payload
//  --------  ---  ---------------------  -------------------------------------------------
//  s_*       in   s_tvalid / s_tready    tdata: raw_word, expected_track; tuser: track_start
//  m_*       out  m_tvalid / m_tready    tdata: data_long, byte_offset; tuser: status;
//                                        tlast: last
//  APB       in   psel / penable         register 0 at byte address 0: sync_word
//
// The block takes one raw word in every cycle while the result register is empty or being
// drained, so the sustained rate is one word per cycle. A result appears in the result
// register in the cycle after the request behind it. The odd data longs sit in one RAM;
// the RAM read for an even long is issued with its high word, so the data is ready when the
// low word comes. After reset the decoder idles until a track start; the odd-long store
// needs no clearing pass because every entry is written before it is read. A stalled result
// holds the input side only while the result register stays full.
`default_nettype none

module mfm_track_sector_decoder #(
	parameter int SECTOR_LONGS      = 128,
	parameter int SECTORS_PER_TRACK = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [15:0] raw_word, [23:16] expected_track
	input  wire logic [23:0]                   s_tdata,
	// [0] track_start
	input  wire logic                          s_tuser,

	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [31:0] data_long, [44:32] byte_offset, [47:45] zero
	output logic      [47:0]                   m_tdata,
	// [1:0] status
	output logic      [1:0]                    m_tuser,
	output logic                               m_tlast,

	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mfm_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	// Word counter spans the odd or even area of a sector (two words per long).
	localparam int WC_W  = $clog2(2 * SECTOR_LONGS + 1);
	localparam int IDX_W = (SECTOR_LONGS > 1) ? $clog2(SECTOR_LONGS) : 1;

	localparam logic [WC_W-1:0] WC_AREA = WC_W'(2 * SECTOR_LONGS);
	localparam logic [WC_W-1:0] WC_SKIP = WC_W'(mfm_pkg::SKIP_WORDS);
	localparam logic [WC_W-1:0] WC_NEXT = WC_W'(mfm_pkg::NEXT_WORDS);
	localparam logic [WC_W-1:0] WC_ONE  = WC_W'(1);
	localparam logic [WC_W-1:0] WC_ZERO = '0;

	// Configuration register.
	logic [15:0] sync_word_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= mfm_pkg::SYNC_RESET;
		end else if (cfg_wr && paddr[2] == mfm_pkg::REG_SYNC_WORD) begin
			sync_word_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[2] == mfm_pkg::REG_SYNC_WORD) begin
			prdata = {16'd0, sync_word_q};
		end else begin
			prdata = '0;
		end
	end

	// Input fields.
	logic [15:0] raw_word;
	logic [7:0]  expected_track;
	logic        track_start;
	logic        in_acc;

	assign raw_word       = s_tdata[15:0];
	assign expected_track = s_tdata[23:16];
	assign track_start    = s_tuser;

	// Decoder state.
	mfm_pkg::phase_t phase_q, phase_d;
	logic [WC_W-1:0] wc_q, wc_d;
	logic [3:0]      sectors_left_q, sectors_left_d;
	logic [3:0]      sector_index_q, sector_index_d;
	logic            gap_follows_q, gap_follows_d;
	logic [15:0]     high_half_q, high_half_d;
	logic [31:0]     odd_info_q, odd_info_d;
	logic [7:0]      target_track_q, target_track_d;

	// Result register.
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic [mfm_pkg::OFF_W-1:0] out_off_q;
	mfm_pkg::status_t  out_status_q;
	logic              out_last_q;

	logic              emit_d;
	logic [31:0]       data_d;
	logic [mfm_pkg::OFF_W-1:0] off_d;
	mfm_pkg::status_t  status_d;
	logic              last_d;

	// Odd-long store ports.
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_idx;
	logic [31:0]       ram_wdata, ram_rdata;

	// The input side stalls only while a finished result is still waiting.
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// The long index inside the odd or even area; always below SECTOR_LONGS.
	assign ram_idx = IDX_W'(wc_q >> 1);

	always_comb begin
		logic [31:0] info;
		logic [31:0] off_full;
		logic        skip_word;

		phase_d        = phase_q;
		wc_d           = wc_q;
		sectors_left_d = sectors_left_q;
		sector_index_d = sector_index_q;
		gap_follows_d  = gap_follows_q;
		high_half_d    = high_half_q;
		odd_info_d     = odd_info_q;
		target_track_d = target_track_q;
		emit_d         = 1'b0;
		data_d         = '0;
		off_d          = '0;
		status_d       = mfm_pkg::ST_DATA;
		last_d         = 1'b0;
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		ram_wdata      = {high_half_q, raw_word};
		info           = mfm_pkg::mfm_join(odd_info_q, {high_half_q, raw_word});
		off_full       = ((32'(sector_index_q) * 32'(SECTOR_LONGS)) + 32'(ram_idx)) << 2;
		skip_word      = 1'b0;

		// A track start restarts the decoder in any phase; a sync word there is dropped.
		if (track_start) begin
			target_track_d = expected_track;
			sectors_left_d = 4'(SECTORS_PER_TRACK);
			sector_index_d = '0;
			gap_follows_d  = 1'b0;
			high_half_d    = '0;
			odd_info_d     = '0;
			wc_d           = WC_ZERO;
			phase_d        = mfm_pkg::PH_INFO;
			skip_word      = (raw_word == sync_word_q);
		end

		if (!skip_word) begin
			case (phase_d)
				mfm_pkg::PH_INFO: begin
					if (!wc_d[0]) begin
						high_half_d = raw_word;
						wc_d        = wc_d + WC_ONE;
					end else if (wc_d == WC_ONE) begin
						odd_info_d = {high_half_d, raw_word};
						wc_d       = wc_d + WC_ONE;
					end else begin
						// Only reached without a track start, so the held state is current.
						wc_d = WC_ZERO;
						if (info[23:16] != target_track_q) begin
							phase_d  = mfm_pkg::PH_IDLE;
							emit_d   = 1'b1;
							data_d   = info;
							status_d = mfm_pkg::ST_BAD_TRACK;
							last_d   = 1'b1;
						end else if (info[15:8] >= 8'(SECTORS_PER_TRACK)) begin
							phase_d  = mfm_pkg::PH_IDLE;
							emit_d   = 1'b1;
							data_d   = info;
							status_d = mfm_pkg::ST_BAD_SECTOR;
							last_d   = 1'b1;
						end else begin
							sector_index_d = info[11:8];
							gap_follows_d  = (info[7:0] == 8'd1);
							phase_d        = mfm_pkg::PH_SKIP;
						end
					end
				end
				mfm_pkg::PH_SKIP: begin
					wc_d = wc_d + WC_ONE;
					if (wc_d >= WC_SKIP) begin
						wc_d    = WC_ZERO;
						phase_d = mfm_pkg::PH_ODD;
					end
				end
				mfm_pkg::PH_ODD: begin
					if (!wc_d[0]) begin
						high_half_d = raw_word;
					end else begin
						ram_we = 1'b1;
					end
					wc_d = wc_d + WC_ONE;
					if (wc_d >= WC_AREA) begin
						wc_d    = WC_ZERO;
						phase_d = mfm_pkg::PH_EVEN;
					end
				end
				mfm_pkg::PH_EVEN: begin
					if (!wc_d[0]) begin
						// Fetch the matching odd long while the low word is on its way.
						high_half_d = raw_word;
						ram_re      = 1'b1;
						wc_d        = wc_d + WC_ONE;
					end else begin
						emit_d   = 1'b1;
						data_d   = mfm_pkg::mfm_join(ram_rdata, {high_half_q, raw_word});
						off_d    = off_full[mfm_pkg::OFF_W-1:0];
						status_d = mfm_pkg::ST_DATA;
						wc_d     = wc_d + WC_ONE;
						if (wc_d >= WC_AREA) begin
							wc_d = WC_ZERO;
							if (sectors_left_d != 4'd0) begin
								sectors_left_d = sectors_left_d - 4'd1;
							end
							if (sectors_left_d == 4'd0) begin
								last_d  = 1'b1;
								phase_d = mfm_pkg::PH_IDLE;
							end else if (gap_follows_q) begin
								phase_d = mfm_pkg::PH_HUNT;
							end else begin
								phase_d = mfm_pkg::PH_NEXT;
							end
						end
					end
				end
				mfm_pkg::PH_NEXT: begin
					wc_d = wc_d + WC_ONE;
					if (wc_d >= WC_NEXT) begin
						wc_d    = WC_ZERO;
						phase_d = mfm_pkg::PH_INFO;
					end
				end
				mfm_pkg::PH_HUNT: begin
					if (raw_word == sync_word_q) begin
						phase_d = mfm_pkg::PH_SYNCS;
					end
				end
				mfm_pkg::PH_SYNCS: begin
					if (raw_word != sync_word_q) begin
						high_half_d = raw_word;
						wc_d        = WC_ONE;
						phase_d     = mfm_pkg::PH_INFO;
					end
				end
				default: begin
					// Idle: words are dropped until a track start.
				end
			endcase
		end

		ram_we = ram_we && in_acc;
		ram_re = ram_re && in_acc;
		emit_d = emit_d && in_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= mfm_pkg::PH_IDLE;
			wc_q           <= WC_ZERO;
			sectors_left_q <= '0;
			sector_index_q <= '0;
			gap_follows_q  <= 1'b0;
			high_half_q    <= '0;
			odd_info_q     <= '0;
			target_track_q <= '0;
		end else if (in_acc) begin
			phase_q        <= phase_d;
			wc_q           <= wc_d;
			sectors_left_q <= sectors_left_d;
			sector_index_q <= sector_index_d;
			gap_follows_q  <= gap_follows_d;
			high_half_q    <= high_half_d;
			odd_info_q     <= odd_info_d;
			target_track_q <= target_track_d;
		end
	end

	// Writes happen only in the odd area and reads only in the even area of a sector, so a
	// read never meets a write to the same entry and no forwarding is needed.
	mfm_ram #(
		.WIDTH(32),
		.DEPTH(SECTOR_LONGS)
	) u_odd_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_idx),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_idx),
		.rdata(ram_rdata)
	);

	// Result register: control under reset, payload loaded with each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_d) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_d) begin
			out_data_q   <= data_d;
			out_off_q    <= off_d;
			out_status_q <= status_d;
			out_last_q   <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_off_q, out_data_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// An error result always closes the track.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != mfm_pkg::ST_DATA) |-> m_tlast)
		else $error("error result without last");

	// The odd-long store is never read and written in the same cycle.
	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("odd store read and write overlap");

	// After the closing result of a track the decoder idles.
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_d && last_d) |=> (phase_q == mfm_pkg::PH_IDLE))
		else $error("decoder not idle after last result");

	// A result is only produced from an accepted request.
	a_emit_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(s_tvalid && s_tready))
		else $error("result without accepted request");
`endif

endmodule

`default_nettype wire

@@ design/mfm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
